/* rtl/hll_pkg.sv */
package hll_pkg;

    localparam int BUCKET_W = 4;
    localparam int VALUE_W  = 7;
    localparam int HASH_W   = 64;

    localparam logic [HASH_W-1:0]  FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
    localparam logic [VALUE_W-1:0] RANK_MAX         = 7'd65;

    typedef enum logic [1:0] {
        OP_ABSORB  = 2'd0,
        OP_END_KEY = 2'd1,
        OP_MERGE   = 2'd2,
        OP_READ    = 2'd3
    } hll_op_t;

    typedef struct packed {
        hll_op_t              operation;
        logic [7:0]           key_byte;
        logic [BUCKET_W-1:0]  bucket_index;
        logic [VALUE_W-1:0]   merge_value;
    } hll_in_t;

    typedef struct packed {
        logic [BUCKET_W-1:0]  bucket;
        logic [VALUE_W-1:0]   value;
        logic                 changed;
    } hll_out_t;

endpackage

/* rtl/hyperloglog_sketch_update_core.sv */
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   hll_in_t  (operation, key_byte, bucket_index,
//                                                     merge_value)
// m_        out        m_valid / m_ready   hll_out_t (bucket, value, changed)
//
// One transaction accepted per cycle unless the output stalls; absorbs give no result.
// Stage one updates the running hash and picks bucket and rank; stage two does the
// read-modify-write of the 16 sketch registers and loads the output register.
// Synchronous reset loads the hash offset basis, zeroes the sketch and clears both valids.
// With m_ready low, up to two transactions are held inside before s_ready drops.
module hyperloglog_sketch_update_core import hll_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hll_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hll_out_t m_data
);

    logic out_free;
    logic a_adv;
    logic accept;
    logic b_move;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic [BUCKET_W-1:0] a_bucket_reg;
    logic [BUCKET_W-1:0] a_bucket_next;
    logic [VALUE_W-1:0]  a_value_reg;
    logic [VALUE_W-1:0]  a_value_next;

    logic [BUCKET_W-1:0] hash_bucket;
    logic [VALUE_W-1:0]  hash_rank;

    logic [VALUE_W-1:0]  sketch_reg  [16];
    logic [VALUE_W-1:0]  sketch_next [16];
    logic [VALUE_W-1:0]  old_value;
    logic                raise;

    logic                m_valid_reg;
    logic                m_valid_next;
    hll_out_t            m_data_reg;
    hll_out_t            m_data_next;

    assign out_free = !m_valid_reg || m_ready;
    assign a_adv    = !a_valid_reg || out_free;
    assign s_ready  = a_adv;
    assign accept   = s_valid && a_adv;
    assign b_move   = a_valid_reg && out_free;

    hll_key_hash u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .absorb   (accept && s_data.operation == OP_ABSORB),
        .finish   (accept && s_data.operation == OP_END_KEY),
        .key_byte (s_data.key_byte),
        .bucket   (hash_bucket),
        .rank     (hash_rank)
    );

    // stage one: reads keep value 0 so the compare never raises the register
    always_comb begin
        a_valid_next  = a_valid_reg;
        a_bucket_next = a_bucket_reg;
        a_value_next  = a_value_reg;
        if (a_adv) begin
            a_valid_next = accept && s_data.operation != OP_ABSORB;
            case (s_data.operation)
                OP_END_KEY: begin
                    a_bucket_next = hash_bucket;
                    a_value_next  = hash_rank;
                end
                OP_MERGE: begin
                    a_bucket_next = s_data.bucket_index;
                    a_value_next  = (s_data.merge_value > RANK_MAX) ? RANK_MAX
                                                                   : s_data.merge_value;
                end
                OP_READ: begin
                    a_bucket_next = s_data.bucket_index;
                    a_value_next  = '0;
                end
                default: begin
                    a_bucket_next = a_bucket_reg;
                    a_value_next  = a_value_reg;
                end
            endcase
        end
    end

    // stage two: read-modify-write of the addressed register
    assign old_value = sketch_reg[a_bucket_reg];
    assign raise     = a_value_reg > old_value;

    always_comb begin
        sketch_next = sketch_reg;
        if (b_move && raise) begin
            sketch_next[a_bucket_reg] = a_value_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next = a_valid_reg;
        end
        if (b_move) begin
            m_data_next.bucket  = a_bucket_reg;
            m_data_next.value   = raise ? a_value_reg : old_value;
            m_data_next.changed = raise;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                sketch_reg[i] <= '0;
            end
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            sketch_reg  <= sketch_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_bucket_reg <= a_bucket_next;
        a_value_reg  <= a_value_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/hll_key_hash.sv */
module hll_key_hash import hll_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                absorb,
    input  logic                finish,
    input  logic [7:0]          key_byte,
    output logic [BUCKET_W-1:0] bucket,
    output logic [VALUE_W-1:0]  rank
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] ctz_x;
    logic [5:0]        tz;

    // FNV prime is 2^40 + 0x1B3, so the multiply is a handful of shifted adds
    always_comb begin
        mixed = hash_reg ^ {56'd0, key_byte};
        hash_next = hash_reg;
        if (absorb) begin
            hash_next = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                      + (mixed << 4) + (mixed << 1) + mixed;
        end else if (finish) begin
            hash_next = FNV_OFFSET_BASIS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= FNV_OFFSET_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

    always_comb begin
        bucket = '0;
        for (int i = 0; i < 8; i++) begin
            bucket = bucket ^ hash_reg[32 + 4*i +: 4];
        end
    end

    // trailing zero count by halving search
    always_comb begin
        ctz_x = hash_reg;
        tz    = '0;
        if (ctz_x[31:0] == 32'd0) begin
            tz[5] = 1'b1;
            ctz_x = ctz_x >> 32;
        end
        if (ctz_x[15:0] == 16'd0) begin
            tz[4] = 1'b1;
            ctz_x = ctz_x >> 16;
        end
        if (ctz_x[7:0] == 8'd0) begin
            tz[3] = 1'b1;
            ctz_x = ctz_x >> 8;
        end
        if (ctz_x[3:0] == 4'd0) begin
            tz[2] = 1'b1;
            ctz_x = ctz_x >> 4;
        end
        if (ctz_x[1:0] == 2'd0) begin
            tz[1] = 1'b1;
            ctz_x = ctz_x >> 2;
        end
        if (ctz_x[0] == 1'b0) begin
            tz[0] = 1'b1;
        end
        rank = (hash_reg == '0) ? RANK_MAX : {1'b0, tz} + 7'd1;
    end

endmodule

/* rtl/hll_checker.sv */
module hll_checker import hll_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input hll_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input hll_out_t m_data
);

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // register values stay in rank range, and a raise never leaves zero
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.value <= RANK_MAX && (!m_data.changed || m_data.value != '0))
        else $error("result value out of range");

    // with the output register empty the pipeline always has room
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind hyperloglog_sketch_update_core hll_checker u_hll_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
